[rtl/pal_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pal_pkg: shared definitions for the positional array list
// Operation and status codes, field widths and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 7;

    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_POS   = 2'd1;
    localparam logic [ST_W-1:0] ST_LIST_FULL = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // latch request, set up pointers, first read
        logic clear;     // empty the list
        logic rd_step;   // read at the read pointer and advance it
        logic wr_shift;  // write read data at the write pointer and advance it
        logic finish;    // close an insert or delete
        logic out_data;  // load the output register with read data
        logic out_stat;  // load the output register with the request status
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_ok;       // incoming request passes its checks
        logic count_zero;   // list is empty
        logic remain_zero;  // no reads left in the current walk
        logic out_free;     // output register can take a result this cycle
    } t_stat;

endpackage
`default_nettype wire

[rtl/pal_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pal_datapath: element memory, length, walk pointers and output register
// Holds the list storage and moves entries one per cycle under command.
// ----------------------------------------------------------------------------
module pal_datapath #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  pal_pkg::t_cmd          i_cmd,
    output pal_pkg::t_stat               o_stat,
    input  wire  [pal_pkg::OP_W-1:0]     i_op,
    input  wire  [pal_pkg::POS_W-1:0]    i_position,
    input  wire  [pal_pkg::DATA_W-1:0]   i_value,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [pal_pkg::ST_W-1:0]     o_status,
    output logic [pal_pkg::DATA_W-1:0]   o_element,
    output logic [pal_pkg::CNT_W-1:0]    o_count,
    output logic                         o_is_empty,
    output logic                         o_last
);
    import pal_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_remain;
    logic [AW-1:0]     r_rd_addr;
    logic [AW-1:0]     r_wr_addr;
    logic [AW-1:0]     r_ins_addr;
    logic [DATA_W-1:0] r_val;
    logic              r_dir_down;
    logic [ST_W-1:0]   r_req_status;

    logic [ST_W-1:0]   req_status;
    logic              pos_zero;
    logic              pos_le_cnt;
    logic              pos_le_cnt1;
    logic              list_full;
    logic [AW-1:0]     rd_addr;
    logic              rd_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              wr_en;
    logic [AW-1:0]     pos_m1;
    logic [CNT_W:0]    ins_moves;

    assign pos_zero    = (i_position == '0);
    assign pos_le_cnt  = (i_position <= r_count);
    assign pos_le_cnt1 = ({1'b0, i_position} <= ({1'b0, r_count} + (CNT_W+1)'(1)));
    assign list_full   = (r_count == CNT_W'(CAPACITY));
    assign pos_m1      = AW'(i_position - POS_W'(1));
    assign ins_moves   = {1'b0, r_count} - {1'b0, i_position} + (CNT_W+1)'(1);

    always_comb begin
        case (i_op)
            OP_GET, OP_DELETE: begin
                req_status = (pos_zero || !pos_le_cnt) ? ST_BAD_POS : ST_OK;
            end
            OP_INSERT: begin
                if (pos_zero || !pos_le_cnt1) begin
                    req_status = ST_BAD_POS;
                end else if (list_full) begin
                    req_status = ST_LIST_FULL;
                end else begin
                    req_status = ST_OK;
                end
            end
            default: begin
                req_status = ST_OK;
            end
        endcase
    end

    // Read port: the first read of a get or dump is issued at acceptance.
    assign rd_en   = i_cmd.start | i_cmd.rd_step;
    assign rd_addr = i_cmd.start ? ((i_op == OP_GET) ? pos_m1 : '0) : r_rd_addr;

    assign wr_en   = i_cmd.wr_shift | (i_cmd.finish & r_dir_down);
    assign wr_addr = i_cmd.wr_shift ? r_wr_addr : r_ins_addr;
    assign wr_data = i_cmd.wr_shift ? r_rdata : r_val;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_val        <= i_value;
            r_ins_addr   <= pos_m1;
            r_req_status <= req_status;
            r_dir_down   <= (i_op == OP_INSERT);
            case (i_op)
                OP_INSERT: begin
                    r_rd_addr <= AW'(r_count - CNT_W'(1));
                    r_wr_addr <= AW'(r_count);
                    r_remain  <= CNT_W'(ins_moves);
                end
                OP_DELETE: begin
                    r_rd_addr <= AW'(i_position);
                    r_wr_addr <= pos_m1;
                    r_remain  <= r_count - CNT_W'(i_position);
                end
                OP_DUMP: begin
                    r_rd_addr <= AW'(1);
                    r_wr_addr <= '0;
                    r_remain  <= r_count - CNT_W'(1);
                end
                default: begin
                    r_rd_addr <= '0;
                    r_wr_addr <= '0;
                    r_remain  <= '0;
                end
            endcase
        end else begin
            if (i_cmd.rd_step) begin
                r_rd_addr <= r_dir_down ? (r_rd_addr - AW'(1)) : (r_rd_addr + AW'(1));
                r_remain  <= r_remain - CNT_W'(1);
            end
            if (i_cmd.wr_shift) begin
                r_wr_addr <= r_dir_down ? (r_wr_addr - AW'(1)) : (r_wr_addr + AW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.finish) begin
            r_count <= r_dir_down ? (r_count + CNT_W'(1)) : (r_count - CNT_W'(1));
        end
    end

    // Output register with its own valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_data || i_cmd.out_stat) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_data) begin
            o_status   <= ST_OK;
            o_element  <= r_rdata;
            o_count    <= r_count;
            o_is_empty <= (r_count == '0);
            o_last     <= (r_remain == '0);
        end else if (i_cmd.out_stat) begin
            o_status   <= r_req_status;
            o_element  <= '0;
            o_count    <= r_count;
            o_is_empty <= (r_count == '0);
            o_last     <= 1'b1;
        end
    end

    assign o_stat.req_ok      = (req_status == ST_OK);
    assign o_stat.count_zero  = (r_count == '0);
    assign o_stat.remain_zero = (r_remain == '0);
    assign o_stat.out_free    = !o_out_valid || i_out_ready;

endmodule
`default_nettype wire

[rtl/pal_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pal_ctrl: request sequencer for the positional array list
// Accepts a request, steps the datapath through shifts or reads, and
// schedules each result into the output register.
// ----------------------------------------------------------------------------
module pal_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire  [pal_pkg::OP_W-1:0]  i_op,
    input  wire  pal_pkg::t_stat      i_stat,
    output pal_pkg::t_cmd             o_cmd
);
    import pal_pkg::*;

    localparam logic [1:0] S_IDLE      = 2'd0;
    localparam logic [1:0] S_SHIFT     = 2'd1;
    localparam logic [1:0] S_EMIT_DATA = 2'd2;
    localparam logic [1:0] S_EMIT_STAT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_pend;
    logic       n_pend;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_pend  = r_pend;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.start = 1'b1;
                    n_pend      = 1'b0;
                    case (i_op)
                        OP_GET: begin
                            n_state = i_stat.req_ok ? S_EMIT_DATA : S_EMIT_STAT;
                        end
                        OP_INSERT, OP_DELETE: begin
                            n_state = i_stat.req_ok ? S_SHIFT : S_EMIT_STAT;
                        end
                        OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            n_state     = S_EMIT_STAT;
                        end
                        OP_DUMP: begin
                            n_state = i_stat.count_zero ? S_EMIT_STAT : S_EMIT_DATA;
                        end
                        default: begin
                            n_state = S_EMIT_STAT;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // A read issued in one cycle is written back in the next.
                o_cmd.rd_step  = !i_stat.remain_zero;
                o_cmd.wr_shift = r_pend;
                n_pend         = !i_stat.remain_zero;
                if (i_stat.remain_zero && !r_pend) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_EMIT_STAT;
                end
            end
            S_EMIT_DATA: begin
                if (i_stat.out_free) begin
                    o_cmd.out_data = 1'b1;
                    if (i_stat.remain_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_step = 1'b1;
                    end
                end
            end
            S_EMIT_STAT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_stat = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

endmodule
`default_nettype wire

[rtl/positional_array_list_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Get, clear, dump of an empty list and rejected or unknown requests load their one result
// in the emit state that follows acceptance, once the output register is free; a dump loads
// its first element the same way, then one per cycle while the output register is free.
// Insert and delete shift entries first. One request at a time; the next waits for idle.
// The walk moves one entry per cycle (one read and one write port on the element memory).
// Reset (synchronous, active low) empties the list and output register; memory is not cleared.
// ----------------------------------------------------------------------------
// positional_array_list_unit: fixed-capacity ordered list of signed words
// Get, insert, delete, clear and dump by 1-based position, with status,
// length and empty flag on every result.
// ----------------------------------------------------------------------------
module positional_array_list_unit #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Request channel.
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [pal_pkg::OP_W-1:0]     i_op,
    input  wire  [pal_pkg::POS_W-1:0]    i_position,
    input  wire  [pal_pkg::DATA_W-1:0]   i_value,
    // Result channel.
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [pal_pkg::ST_W-1:0]     o_status,
    output logic [pal_pkg::DATA_W-1:0]   o_element,
    output logic [pal_pkg::CNT_W-1:0]    o_count,
    output logic                         o_is_empty,
    output logic                         o_last
);
    import pal_pkg::*;

    // The controller only sequences; all storage and arithmetic live in the
    // datapath. A result sits in the datapath's output register so that the
    // controller can go back to idle and take the next request while the
    // result waits for its transfer.
    t_cmd  cmd;
    t_stat stat;

    pal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Insert shifts entries up from the tail toward the insert point, delete
    // shifts them down from the removed entry to the tail; in both cases a
    // read and the write of the previous read overlap, so one entry moves
    // per cycle.
    pal_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (i_op),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_element   (o_element),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

[tb/pal_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_checker: scoreboard for the positional array list
// Watches both channels of the list unit, keeps a shadow copy of the list,
// works out the results of every accepted request and compares each result
// transfer, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module pal_checker #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire                          i_in_ready,
    input  wire  [pal_pkg::OP_W-1:0]     i_op,
    input  wire  [pal_pkg::POS_W-1:0]    i_position,
    input  wire  [pal_pkg::DATA_W-1:0]   i_value,
    input  wire                          i_out_valid,
    input  wire                          i_out_ready,
    input  wire  [pal_pkg::ST_W-1:0]     i_status,
    input  wire  [pal_pkg::DATA_W-1:0]   i_element,
    input  wire  [pal_pkg::CNT_W-1:0]    i_count,
    input  wire                          i_is_empty,
    input  wire                          i_last,
    output int                           o_fail_count,
    output int                           o_pending
);
    import pal_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] element;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
        logic              last;
    } t_list_result;

    t_list_result      expected_results[$];
    logic [DATA_W-1:0] shadow_list[CAPACITY];
    int                shadow_len;
    int                mismatches;

    initial begin
        shadow_len   = 0;
        mismatches   = 0;
    end

    // Every result reports the length as it stands after the request.
    function automatic t_list_result make_result(input logic [ST_W-1:0] st,
                                                 input logic [DATA_W-1:0] elem,
                                                 input logic fin);
        t_list_result res;
        res.status   = st;
        res.element  = elem;
        res.count    = shadow_len[CNT_W-1:0];
        res.is_empty = (shadow_len == 0);
        res.last     = fin;
        return res;
    endfunction

    task automatic apply_request(input logic [OP_W-1:0] op, input int pos,
                                 input logic [DATA_W-1:0] val);
        int i;
        case (op)
            OP_GET: begin
                if (pos < 1 || pos > shadow_len)
                    expected_results.push_back(make_result(ST_BAD_POS, '0, 1'b1));
                else
                    expected_results.push_back(make_result(ST_OK, shadow_list[pos-1], 1'b1));
            end
            OP_INSERT: begin
                // A bad position wins over a full list.
                if (pos < 1 || pos > shadow_len + 1) begin
                    expected_results.push_back(make_result(ST_BAD_POS, '0, 1'b1));
                end else if (shadow_len >= CAPACITY) begin
                    expected_results.push_back(make_result(ST_LIST_FULL, '0, 1'b1));
                end else begin
                    for (i = shadow_len; i > pos - 1; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos-1] = val;
                    shadow_len++;
                    expected_results.push_back(make_result(ST_OK, '0, 1'b1));
                end
            end
            OP_DELETE: begin
                if (pos < 1 || pos > shadow_len) begin
                    expected_results.push_back(make_result(ST_BAD_POS, '0, 1'b1));
                end else begin
                    for (i = pos; i < shadow_len; i++)
                        shadow_list[i-1] = shadow_list[i];
                    shadow_len--;
                    expected_results.push_back(make_result(ST_OK, '0, 1'b1));
                end
            end
            OP_CLEAR: begin
                shadow_len = 0;
                expected_results.push_back(make_result(ST_OK, '0, 1'b1));
            end
            OP_DUMP: begin
                if (shadow_len == 0) begin
                    expected_results.push_back(make_result(ST_OK, '0, 1'b1));
                end else begin
                    for (i = 0; i < shadow_len; i++)
                        expected_results.push_back(
                            make_result(ST_OK, shadow_list[i], i + 1 == shadow_len));
                end
            end
            default: begin
                expected_results.push_back(make_result(ST_OK, '0, 1'b1));
            end
        endcase
    endtask

    task automatic check_result();
        t_list_result got;
        t_list_result want;
        got = {i_status, i_element, i_count, i_is_empty, i_last};
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with nothing outstanding: st=%0d el=%0d cnt=%0d e=%0b l=%0b",
                         $realtime, got.status, $signed(got.element), got.count,
                         got.is_empty, got.last);
        end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result differs: expected st=%0d el=%0d cnt=%0d e=%0b l=%0b,",
                              " got st=%0d el=%0d cnt=%0d e=%0b l=%0b"},
                             $realtime, want.status, $signed(want.element), want.count,
                             want.is_empty, want.last, got.status, $signed(got.element),
                             got.count, got.is_empty, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_len = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_in_valid && i_in_ready)
                apply_request(i_op, int'(i_position), i_value);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level testbench for positional_array_list_unit
// Drives requests with random gaps, stalls the result side at random, and
// leaves all prediction and comparison to pal_checker.
// ----------------------------------------------------------------------------
module tb;
    import pal_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int TOTAL_ITEMS  = 370;
    // No transfer on either side for this many cycles means the unit hung.
    // The worst legal quiet stretch is the long result hold-off plus one walk.
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 45;
    localparam int DRAIN_CYCLES = 100;

    // Op codes the unit does not define; it answers them with a plain result.
    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

    typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} t_burst_mode;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_in_valid = 1'b0;
    logic [OP_W-1:0]     i_op       = '0;
    logic [POS_W-1:0]    i_position = '0;
    logic [DATA_W-1:0]   i_value    = '0;
    logic                i_out_ready = 1'b0;

    wire                 o_in_ready;
    wire                 o_out_valid;
    wire  [ST_W-1:0]     o_status;
    wire  [DATA_W-1:0]   o_element;
    wire  [CNT_W-1:0]    o_count;
    wire                 o_is_empty;
    wire                 o_last;

    int fail_count;
    int pending;

    // Stimulus-side view of the list length, used to aim positions and to fill the list.
    int list_len    = 0;
    int items_sent  = 0;
    int calm_items  = 0;
    int idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    positional_array_list_unit #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_position (i_position),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status   (o_status),
        .o_element  (o_element),
        .o_count    (o_count),
        .o_is_empty (o_is_empty),
        .o_last     (o_last)
    );

    pal_checker #(
        .CAPACITY(CAPACITY)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_position  (i_position),
        .i_value     (i_value),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (o_status),
        .i_element   (o_element),
        .i_count     (o_count),
        .i_is_empty  (o_is_empty),
        .i_last      (o_last),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Gap lengths: mostly from the shortest range, sometimes the middle one, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Most positions land in the legal range 1..hi; the rest roam the whole
    // field so that zero and the top bits of the position keep showing up.
    function automatic int pick_position(input int hi);
        if (hi >= 1 && $urandom_range(0, 99) < 85)
            return $urandom_range(1, hi);
        else
            return $urandom_range(0, (1 << POS_W) - 1);
    endfunction

    // Offers one request and returns at the edge where it is accepted. It is
    // always entered right after a rising edge. With no gap, valid simply
    // stays high and only the payload changes for the next transfer.
    task automatic send_request(input logic [OP_W-1:0] op, input int pos,
                                input logic [DATA_W-1:0] val);
        int gap;
        gap = 0;
        if (calm_items > 0)
            calm_items--;
        else if ($urandom_range(0, 9) == 0)
            calm_items = $urandom_range(10, 30);
        else if ($urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_position <= pos[POS_W-1:0];
        i_value    <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        case (op)
            OP_INSERT: if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) list_len++;
            OP_DELETE: if (pos >= 1 && pos <= list_len) list_len--;
            OP_CLEAR:  list_len = 0;
            default:   ;
        endcase
        // Spare op codes only get a plain result from the unit and do not count as work.
        if (op <= OP_DUMP)
            items_sent++;
    endtask

    // Stops offering requests until the checker has nothing outstanding. The
    // first edge lets the checker's count catch up with the last transfer.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, calm stretches with ready held high, and one
    // long hold-off once the run is well under way. While it lasts the sender
    // keeps offering, so the unit backs up and stops taking requests.
    initial begin : result_side
        int taken;
        int gap_left;
        int calm_left;
        bit held;
        taken     = 0;
        gap_left  = 0;
        calm_left = 0;
        held      = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (o_out_valid && i_out_ready)
                taken++;
            if (gap_left > 0) begin
                gap_left--;
                i_out_ready <= 1'b0;
            end else if (!held && taken >= HOLD_AFTER) begin
                held        = 1'b1;
                gap_left    = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                i_out_ready <= 1'b1;
            end else if ($urandom_range(0, 19) == 0) begin
                calm_left   = $urandom_range(20, 80);
                i_out_ready <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                gap_left    = pick_gap() - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_burst_mode mode;
        int          burst_left;
        int          p_ins;
        int          p_del;
        int          r;
        burst_left = 0;
        mode       = MODE_MIXED;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: the empty list, the value extremes, positions at and
        // just past each end of the range, dump of a short list, spare op codes
        // and a clear followed by a dump of the emptied list.
        send_request(OP_GET,    1,   '0);
        send_request(OP_GET,    0,   '0);
        send_request(OP_DUMP,   0,   '0);
        send_request(OP_DELETE, 1,   '0);
        send_request(OP_INSERT, 2,   32'h1234_5678);
        send_request(OP_INSERT, 1,   32'h8000_0000);
        send_request(OP_INSERT, 2,   32'h7FFF_FFFF);
        send_request(OP_INSERT, 1,   32'hFFFF_FFFF);
        send_request(OP_INSERT, 127, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 4,   32'h0000_0000);
        send_request(OP_GET,    0,   '0);
        send_request(OP_GET,    1,   '0);
        send_request(OP_GET,    4,   '0);
        send_request(OP_GET,    5,   '0);
        send_request(OP_GET,    127, '0);
        send_request(OP_DUMP,   127, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 2,   '0);
        send_request(OP_DELETE, 0,   '0);
        send_request(OP_DELETE, 127, '0);
        send_request(OP_DELETE, 3,   '0);
        send_request(OP_SPARE_LO,  1,   '0);
        send_request(OP_SPARE_MID, 127, 32'hFFFF_FFFF);
        send_request(OP_SPARE_HI,  0,   '0);
        send_request(OP_CLEAR,  0,   '0);
        send_request(OP_DUMP,   1,   '0);
        wait_drained();

        // Fill to capacity, then knock on the full list: a legal position must
        // report full, the position just past the end too, one further out is
        // a bad position. Finish with reads, a dump and a delete at the top end.
        while (list_len < CAPACITY)
            send_request(OP_INSERT, $urandom_range(1, list_len + 1), $urandom);
        send_request(OP_INSERT, CAPACITY + 1, $urandom);
        send_request(OP_INSERT, $urandom_range(1, CAPACITY), $urandom);
        send_request(OP_INSERT, CAPACITY + 2, $urandom);
        send_request(OP_GET,    CAPACITY, '0);
        send_request(OP_GET,    CAPACITY + 1, '0);
        send_request(OP_DUMP,   0, '0);
        send_request(OP_DELETE, CAPACITY, '0);
        wait_drained();

        // Random bursts that lean toward growing, shrinking or neither, so the
        // length wanders over the whole range rather than hovering near zero.
        while (items_sent < TOTAL_ITEMS) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(10, 40);
                mode       = t_burst_mode'($urandom_range(0, 2));
            end
            burst_left--;
            case (mode)
                MODE_GROW:   begin p_ins = 60; p_del = 10; end
                MODE_SHRINK: begin p_ins = 15; p_del = 55; end
                default:     begin p_ins = 30; p_del = 25; end
            endcase
            r = $urandom_range(0, 99);
            if (r < p_ins)
                send_request(OP_INSERT, pick_position(list_len + 1), $urandom);
            else if (r < p_ins + p_del)
                send_request(OP_DELETE, pick_position(list_len), $urandom);
            else if (r < p_ins + p_del + 4)
                send_request(OP_DUMP, $urandom_range(0, 127), $urandom);
            else if (r < p_ins + p_del + 6)
                send_request(OP_CLEAR, $urandom_range(0, 127), $urandom);
            else if (r < p_ins + p_del + 8)
                send_request(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                             $urandom_range(0, 127), $urandom);
            else
                send_request(OP_GET, pick_position(list_len), $urandom);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
